>>> rtl/core/npe_pkg.sv
// Shared types and constants for the NMEA position extractor.
// Used by the front parser, the command queue, the back scaler and the top level.
package npe_pkg;

	// digits of the integer part (ddmm or dddmm) held as a binary value
	localparam int INT_W = 15;
	// minute fraction held in units of 1e-7 minute, always below 1e7
	localparam int FRAC_W = 24;

	// command queue between the parser and the scaler
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// one command word from the parser to the scaler
	typedef struct packed {
		logic              wr_lat;      // a latitude field closed
		logic              wr_lon;      // a longitude field closed
		logic              emit;        // a good sentence ended, give a result
		logic              kind;        // 1 for RMC, 0 for GGA
		logic [3:0]        hemi;        // lat set, lat south, lon set, lon west
		logic              zero;        // closing field empty, not numeric or too large
		logic [INT_W-1:0]  int_digits;  // integer part of the closing field
		logic [FRAC_W-1:0] frac;        // minute fraction in 1e-7 minute
	} npe_cmd_t;

endpackage

>>> rtl/core/npe_front.sv
// Byte parser: sentence framing, tag match, field decode and hemisphere tracking.
// Depends on npe_pkg; issues command words to the queue when a field closes.
module npe_front import npe_pkg::*; #(
	parameter int MINUTE_FRACTION_DIGITS = 5
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  logic [7:0] rx_byte,
	output logic     push,
	output npe_cmd_t push_word
);

	localparam int CNT_W = $clog2(MINUTE_FRACTION_DIGITS + 1);

	// characters of interest
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	// tag match progress through the first field
	localparam logic [3:0] TAG_DOLLAR = 4'd1;
	localparam logic [3:0] TAG_G      = 4'd2;
	localparam logic [3:0] TAG_GP     = 4'd3;
	localparam logic [3:0] TAG_GPG    = 4'd4;
	localparam logic [3:0] TAG_GPGG   = 4'd5;
	localparam logic [3:0] TAG_GGA    = 4'd6;
	localparam logic [3:0] TAG_GPR    = 4'd7;
	localparam logic [3:0] TAG_GPRM   = 4'd8;
	localparam logic [3:0] TAG_RMC    = 4'd9;
	localparam logic [3:0] TAG_BAD    = 4'd15;

	localparam logic [3:0] FIELD_LAST = 4'd15;
	localparam logic [3:0] FIELD_MIN  = 4'd5;

	typedef struct packed {
		logic [3:0]        field;
		logic [3:0]        tag;
		logic [INT_W-1:0]  int_digits;
		logic [FRAC_W-1:0] frac;
		logic [CNT_W-1:0]  cnt;
		logic [2:0]        flags;   // not empty, bad, dot seen
		logic [3:0]        hemi;
	} fe_state_t;

	fe_state_t state_q;
	logic      in_sentence_q;
	logic      saw_cr_q;

	fe_state_t st_cr;
	fe_state_t st_nx;
	fe_state_t closing_st;
	logic      in_sentence_d;
	logic      saw_cr_d;
	logic      close_now;
	logic      emit_now;
	logic [3:0] close_base;

	// weight of a fraction digit in units of 1e-7 minute
	function automatic logic [19:0] place_weight(input logic [CNT_W-1:0] cnt);
		logic [19:0] w;
		case (3'(cnt))
			3'd0: w = 20'd1000000;
			3'd1: w = 20'd100000;
			3'd2: w = 20'd10000;
			3'd3: w = 20'd1000;
			3'd4: w = 20'd100;
			3'd5: w = 20'd10;
			default: w = 20'd1;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] base_of(input logic [3:0] tag);
		return (tag == TAG_RMC) ? 4'd3 : 4'd2;
	endfunction

	function automatic logic [3:0] tag_next(input logic [3:0] t, input logic [7:0] c);
		logic [3:0] n;
		n = TAG_BAD;
		case (t)
			TAG_DOLLAR: if (c == CH_G) n = TAG_G;
			TAG_G:      if (c == CH_P) n = TAG_GP;
			TAG_GP: begin
				if (c == CH_G) n = TAG_GPG;
				else if (c == CH_R) n = TAG_GPR;
			end
			TAG_GPG:    if (c == CH_G) n = TAG_GPGG;
			TAG_GPGG:   if (c == CH_A) n = TAG_GGA;
			TAG_GPR:    if (c == CH_M) n = TAG_GPRM;
			TAG_GPRM:   if (c == CH_C) n = TAG_RMC;
			default:    n = TAG_BAD;
		endcase
		return n;
	endfunction

	// hemisphere flags once the current field is closed
	function automatic logic [3:0] hemi_closed(input fe_state_t st);
		logic [3:0] r;
		logic [3:0] base;
		logic       neg;
		r = st.hemi;
		base = base_of(st.tag);
		neg = st.flags[0] && !st.flags[1];
		if (st.field == base + 4'd1) r[1:0] = {neg, st.flags[0]};
		else if (st.field == base + 4'd3) r[3:2] = {neg, st.flags[0]};
		return r;
	endfunction

	// one ordinary character into the current field
	function automatic fe_state_t take_char(input fe_state_t st, input logic [7:0] c);
		fe_state_t   r;
		logic [3:0]  base;
		logic [3:0]  d;
		logic [18:0] v;
		r = st;
		base = base_of(st.tag);
		d = c[3:0];
		v = 19'(st.int_digits) * 19'd10 + 19'(d);
		if (st.field == 4'd0) begin
			r.tag = tag_next(st.tag, c);
		end else if (st.field == base || st.field == base + 4'd2) begin
			r.flags[0] = 1'b1;
			if (!st.flags[1]) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					if (st.flags[2]) begin
						if (st.cnt < CNT_W'(MINUTE_FRACTION_DIGITS)) begin
							r.frac = st.frac + FRAC_W'(d) * FRAC_W'(place_weight(st.cnt));
							r.cnt = st.cnt + CNT_W'(1);
						end
					end else if (v > 19'd32767) begin
						r.flags[1] = 1'b1;
					end else begin
						r.int_digits = v[INT_W-1:0];
					end
				end else if (c == CH_DOT && !st.flags[2]) begin
					r.flags[2] = 1'b1;
				end else begin
					r.flags[1] = 1'b1;
				end
			end
		end else if (st.field == base + 4'd1 || st.field == base + 4'd3) begin
			if (st.flags[0] || (c != CH_S && c != CH_W)) r.flags[1] = 1'b1;
			r.flags[0] = 1'b1;
		end
		return r;
	endfunction

	// close the field on a comma and open the next one
	function automatic fe_state_t next_field(input fe_state_t st);
		fe_state_t r;
		r = st;
		r.hemi = hemi_closed(st);
		if (st.field != FIELD_LAST) r.field = st.field + 4'd1;
		r.int_digits = '0;
		r.frac = '0;
		r.cnt = '0;
		r.flags = '0;
		return r;
	endfunction

	// byte classification and next parser state
	always_comb begin
		st_cr = state_q;
		st_nx = state_q;
		closing_st = state_q;
		in_sentence_d = in_sentence_q;
		saw_cr_d = saw_cr_q;
		close_now = 1'b0;
		emit_now = 1'b0;
		if (!in_sentence_q) begin
			if (rx_byte == CH_DOLLAR) begin
				st_nx = '0;
				st_nx.tag = TAG_DOLLAR;
				in_sentence_d = 1'b1;
			end
		end else if (saw_cr_q && rx_byte == CH_LF) begin
			close_now = 1'b1;
			emit_now = (state_q.tag == TAG_GGA || state_q.tag == TAG_RMC) &&
				(state_q.field >= FIELD_MIN);
			st_nx.hemi = hemi_closed(state_q);
			in_sentence_d = 1'b0;
			saw_cr_d = 1'b0;
		end else begin
			// a lone carriage return is an ordinary character
			if (saw_cr_q) st_cr = take_char(state_q, CH_CR);
			closing_st = st_cr;
			if (rx_byte == CH_CR) begin
				saw_cr_d = 1'b1;
				st_nx = st_cr;
			end else begin
				saw_cr_d = 1'b0;
				if (rx_byte == CH_COMMA) begin
					close_now = 1'b1;
					st_nx = next_field(st_cr);
				end else begin
					st_nx = take_char(st_cr, rx_byte);
				end
			end
		end
	end

	// command word for the scaler
	always_comb begin
		close_base = base_of(closing_st.tag);
		push_word.wr_lat = close_now && closing_st.field == close_base;
		push_word.wr_lon = close_now && closing_st.field == close_base + 4'd2;
		push_word.emit = emit_now;
		push_word.kind = closing_st.tag == TAG_RMC;
		push_word.hemi = hemi_closed(closing_st);
		push_word.zero = !closing_st.flags[0] || closing_st.flags[1];
		push_word.int_digits = closing_st.int_digits;
		push_word.frac = closing_st.frac;
	end

	assign push = take && (push_word.wr_lat || push_word.wr_lon || push_word.emit);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			in_sentence_q <= 1'b0;
			saw_cr_q <= 1'b0;
		end else if (take) begin
			state_q <= st_nx;
			in_sentence_q <= in_sentence_d;
			saw_cr_q <= saw_cr_d;
		end
	end

endmodule

>>> rtl/core/npe_queue.sv
// Short command queue between the parser and the scaler.
// Depends on npe_pkg for the command word and the queue depth.
module npe_queue import npe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  npe_cmd_t push_word,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output npe_cmd_t head
);

	npe_cmd_t            slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_word;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (push && !pop) count_q <= count_q + (QUEUE_AW + 1)'(1);
			else if (pop && !push) count_q <= count_q - (QUEUE_AW + 1)'(1);
		end
	end

endmodule

>>> rtl/core/npe_back.sv
// Scaler: turns ddmm.mmmm fields into 1e-7 degree and drives the result register.
// Depends on npe_pkg; four pipeline stages then the output register.
module npe_back import npe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  npe_cmd_t    head,
	input  logic        empty,
	output logic        pop,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [30:0] latitude,
	output logic [31:0] longitude,
	output logic        sentence_kind
);

	// floor(i / 100) = (i * 20972) >> 21, exact for i below 32768
	localparam logic [INT_W-1:0] DIV100_MUL = 15'd20972;
	localparam int DIV100_SHIFT = 21;
	// floor(y / 15) = (y * 286331154) >> 32, exact for y below 2^28
	localparam logic [28:0] DIV15_MUL = 29'd286331154;
	localparam int DIV15_SHIFT = 32;
	localparam logic [31:0] DEG_SCALE = 32'd10000000;
	localparam logic [29:0] LAT_LIMIT = 30'd900000000;
	localparam logic [30:0] LON_LIMIT = 31'd1800000000;

	logic        advance;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	npe_cmd_t    cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [8:0]  q100_s1;
	logic [6:0]  rem_s2;
	logic [31:0] deg_s2, deg_s3, deg_s4;
	logic [29:0] x_s3;
	logic [23:0] q60_s4;

	logic [29:0] prod100;
	logic [6:0]  rem_d;
	logic [29:0] x_d;
	logic [56:0] prod15;
	logic [32:0] mag;
	logic [29:0] lat_mag, lat_held_q, lat_cur;
	logic [30:0] lon_mag, lon_held_q, lon_cur;
	logic [30:0] lat_out;
	logic [31:0] lon_out;

	logic        out_valid_q;
	logic [30:0] latitude_q;
	logic [31:0] longitude_q;
	logic        kind_q;

	// the whole pipe moves unless a result is waiting and not taken
	assign advance = !out_valid_q || out_ready;
	assign pop = advance && !empty;

	// degrees and minutes split, minutes scaled to 1e-7 minute, then divided by 60
	always_comb begin
		prod100 = 30'(head.int_digits) * 30'(DIV100_MUL);
		rem_d = 7'(cmd_s1.int_digits - INT_W'(16'(q100_s1) * 16'd100));
		x_d = 30'(rem_s2) * 30'(DEG_SCALE) + 30'(cmd_s2.frac);
		prod15 = 57'(x_s3[29:2]) * 57'(DIV15_MUL);
	end

	// final sum, saturation and sign
	always_comb begin
		mag = 33'(deg_s4) + 33'(q60_s4);
		if (cmd_s4.zero) lat_mag = '0;
		else if (mag > 33'(LAT_LIMIT)) lat_mag = LAT_LIMIT;
		else lat_mag = mag[29:0];
		if (cmd_s4.zero) lon_mag = '0;
		else if (mag > 33'(LON_LIMIT)) lon_mag = LON_LIMIT;
		else lon_mag = mag[30:0];
		lat_cur = (valid_s4 && cmd_s4.wr_lat) ? lat_mag : lat_held_q;
		lon_cur = (valid_s4 && cmd_s4.wr_lon) ? lon_mag : lon_held_q;
		if (!cmd_s4.hemi[0]) lat_out = '0;
		else if (cmd_s4.hemi[1]) lat_out = 31'(0) - 31'(lat_cur);
		else lat_out = 31'(lat_cur);
		if (!cmd_s4.hemi[2]) lon_out = '0;
		else if (cmd_s4.hemi[3]) lon_out = 32'(0) - 32'(lon_cur);
		else lon_out = 32'(lon_cur);
	end

	// stage valids and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= !empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			out_valid_q <= valid_s4 && cmd_s4.emit;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1 <= head;
			q100_s1 <= 9'(prod100 >> DIV100_SHIFT);
			cmd_s2 <= cmd_s1;
			rem_s2 <= rem_d;
			deg_s2 <= 32'(q100_s1) * DEG_SCALE;
			cmd_s3 <= cmd_s2;
			x_s3 <= x_d;
			deg_s3 <= deg_s2;
			cmd_s4 <= cmd_s3;
			q60_s4 <= 24'(prod15 >> DIV15_SHIFT);
			deg_s4 <= deg_s3;
		end
	end

	// held magnitudes and the result register
	always_ff @(posedge clk) begin
		if (advance && valid_s4) begin
			if (cmd_s4.wr_lat) lat_held_q <= lat_mag;
			if (cmd_s4.wr_lon) lon_held_q <= lon_mag;
			if (cmd_s4.emit) begin
				latitude_q <= lat_out;
				longitude_q <= lon_out;
				kind_q <= cmd_s4.kind;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign latitude = latitude_q;
	assign longitude = longitude_q;
	assign sentence_kind = kind_q;

endmodule

>>> rtl/core/nmea_position_extractor.sv
// NMEA position extractor: takes one ASCII word per cycle, with no gaps needed,
// and gives latitude and longitude in 1e-7 degree for each $GPGGA or $GPRMC
// sentence with at least six fields. A result passes from the LF that ends its
// sentence through the command queue, the four scaler stages and the output
// register. The byte parser sustains one word per cycle; the four-word command
// queue lets it keep accepting while a result waits on the output, and in_ready
// falls only when that queue is full.
// Depends on npe_pkg, npe_front, npe_queue and npe_back.
module nmea_position_extractor import npe_pkg::*; #(
	parameter int MINUTE_FRACTION_DIGITS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] latitude,
	output logic [31:0] longitude,
	output logic        sentence_kind
);

	logic     take;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	npe_cmd_t push_word;
	npe_cmd_t head;

	// a word is taken whenever the queue has room
	assign in_ready = !q_full;
	assign take = in_valid && in_ready;

	npe_front #(
		.MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_word (push_word)
	);

	npe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	npe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.latitude      (latitude),
		.longitude     (longitude),
		.sentence_kind (sentence_kind)
	);

endmodule

>>> rtl/core/npe_checker.sv
// Port-level checks for the NMEA position extractor.
// Bound to nmea_position_extractor; sees its ports only.
module npe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] latitude,
	input logic [31:0] longitude,
	input logic        sentence_kind
);

	// a stalled result word stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(latitude) && $stable(longitude) && $stable(sentence_kind))
		else $error("result payload changed while stalled");

	// latitude saturates at ninety degrees either way
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(latitude) <= 31'sd900000000 &&
			$signed(latitude) >= -31'sd900000000))
		else $error("latitude out of range");

	// longitude saturates at one hundred and eighty degrees either way
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(longitude) <= 32'sd1800000000 &&
			$signed(longitude) >= -32'sd1800000000))
		else $error("longitude out of range");

endmodule

bind nmea_position_extractor npe_checker u_npe_checker (.*);
